// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge, masked during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/bsbe_pkg.sv -----
// Package for the B-spline basis evaluator: widths, constants, state codes.
// No dependencies.
package bsbe_pkg;
   localparam int MaxOrder  = 8;
   localparam int KnotDepth = 64;
   localparam int FracBits  = 16;
   localparam int ValBits   = FracBits + 1;
   localparam int IdxBits   = $clog2(KnotDepth);
   localparam int OrdBits   = $clog2(MaxOrder + 1);
   localparam int BasIdxBits = $clog2(MaxOrder);
   localparam int DenBits   = ValBits + 1;
   localparam int QuoBits   = ValBits + FracBits + 1;
   localparam int DivCntBits = $clog2(QuoBits + 1);
   localparam int ProdBits  = DenBits + QuoBits;
   localparam logic [ValBits-1:0] OneVal = ValBits'(1) << FracBits;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;
   localparam logic [0:0] CSR_ORDER = 1'b0;
   localparam logic [0:0] CSR_COUNT = 1'b1;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_SRD    = 12'b000000000010,
      ST_SCMP   = 12'b000000000100,
      ST_KRDL   = 12'b000000001000,
      ST_KRDR   = 12'b000000010000,
      ST_KSTR   = 12'b000000100000,
      ST_DIVST  = 12'b000001000000,
      ST_DIV    = 12'b000010000000,
      ST_MULR   = 12'b000100000000,
      ST_MULL   = 12'b001000000000,
      ST_EMIT   = 12'b010000000000,
      ST_WAIT   = 12'b100000000000
   } state_type;

   function automatic logic [ValBits-1:0] sat_one(input logic [ProdBits-1:0] v);
      logic [ValBits-1:0] r;
      r = (v > ProdBits'(OneVal)) ? OneVal : v[ValBits-1:0];
      return r;
   endfunction
endpackage

// ----- design/bspline_basis_eval_top.sv -----
// Load writes one knot per accepted request. Evaluate: a linear span search, then per level j
// the knot states KRDL, KRDR and KSTR, then per step r a set-up, a serial restoring divide and
// two multiplies; then the result beats are emitted, each held until rsp_tready.
// One item at a time; req_tready is low while an evaluation runs.
// Synchronous active-high reset returns order and count to 4; knots are undefined.
`include "assert_macros.svh"
module bspline_basis_eval_top
   import bsbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [5:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // knot_index[5:0], knot_value[22:6], param_u[39:23]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // basis_index[5:0], basis_value[22:6], span_index[28:23]
   output logic        rsp_tlast    // last_value
);
   state_type state_ff, state_in;
   logic [3:0] ord_cfg_ff;
   logic [5:0] cnt_cfg_ff;
   logic [OrdBits-1:0] ord_ff;    // clamped order
   logic [IdxBits:0]   n_ff;      // clamped count
   logic [ValBits-1:0] u_ff;
   logic [IdxBits-1:0] span_ff;
   logic [IdxBits:0]   k_ff;      // search index / emit index
   logic [OrdBits-1:0] j_ff, r_ff;
   logic [ValBits-1:0] left_ff  [MaxOrder+1];
   logic [ValBits-1:0] right_ff [MaxOrder+1];
   logic [ValBits-1:0] basis_ff [MaxOrder];
   logic [ValBits-1:0] saved_ff;
   logic [QuoBits-1:0] quo_ff;    // dividend shifts out, quotient in
   logic [DenBits:0]   rem_ff;
   logic [DenBits-1:0] den_ff;
   logic [DivCntBits-1:0] dcnt_ff;
   logic [ProdBits-1:0] prod_ff;
   logic [31:0] rsp_data_ff;
   logic rsp_last_ff, rsp_valid_ff;

   logic [IdxBits-1:0] rd_addr;
   logic [ValBits-1:0] rd_data;
   logic acc_req, knot_wr;

   assign acc_req = req_tvalid && req_tready;
   assign knot_wr = acc_req && (req_tuser == REQ_LOAD);
   assign req_tready = (state_ff == ST_IDLE);

   bsbe_ram #(.Width(ValBits), .Depth(KnotDepth)) u_knots (
      .clock  (clock),
      .wr_en  (knot_wr),
      .wr_addr(req_tdata[IdxBits-1:0]),
      .wr_data(req_tdata[22:6]),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Clamped parameters from the registers.
   logic [3:0] ord_c;
   logic [6:0] n_c;
   always_comb begin
      ord_c = ord_cfg_ff;
      if (ord_c < 4'd2) ord_c = 4'd2;
      if (ord_c > 4'(MaxOrder)) ord_c = 4'(MaxOrder);
      n_c = 7'(cnt_cfg_ff);
      if (n_c > 7'(KnotDepth) - 7'(ord_c)) n_c = 7'(KnotDepth) - 7'(ord_c);
      if (n_c < 7'(ord_c)) n_c = 7'(ord_c);
   end

   // Knot address per state.
   logic [IdxBits+1:0] addr_w;
   always_comb begin
      addr_w = '0;
      case (state_ff)
         ST_SRD, ST_SCMP: addr_w = (IdxBits+2)'(k_ff);
         ST_KRDL: addr_w = (IdxBits+2)'(span_ff) + 1'b1 - (IdxBits+2)'(j_ff);
         ST_KRDR, ST_KSTR: addr_w = (IdxBits+2)'(span_ff) + (IdxBits+2)'(j_ff);
         default: addr_w = '0;
      endcase
      rd_addr = addr_w[IdxBits-1:0];
   end

   logic [OrdBits-1:0] p_w;
   assign p_w = ord_ff - 1'b1;

   logic [ValBits-1:0] rt_w, lt_w;
   assign rt_w = right_ff[r_ff + 1'b1];
   assign lt_w = left_ff[j_ff - r_ff];

   logic [DenBits:0] rem_sh, rem_sub;
   assign rem_sh  = {rem_ff[DenBits-1:0], quo_ff[QuoBits-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   logic [ValBits-1:0] sum_w;
   assign sum_w = sat_one(ProdBits'(saved_ff) + (prod_ff >> FracBits));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (acc_req && req_tuser == REQ_EVAL) state_in = ST_SRD;
         ST_SRD:   state_in = ST_SCMP;
         ST_SCMP:  state_in = (k_ff + 1'b1 >= n_ff) ? ST_KRDL : ST_SRD;
         ST_KRDL:  state_in = ST_KRDR;
         ST_KRDR:  state_in = ST_KSTR;
         ST_KSTR:  state_in = ST_DIVST;
         ST_DIVST: state_in = ST_DIV;
         ST_DIV:   if (dcnt_ff == '0) state_in = ST_MULR;
         ST_MULR:  state_in = ST_MULL;
         ST_MULL:  begin
            if (r_ff + 1'b1 < j_ff) state_in = ST_DIVST;
            else if (j_ff + 1'b1 < ord_ff) state_in = ST_KRDL;
            else state_in = ST_EMIT;
         end
         ST_EMIT:  state_in = ST_WAIT;
         ST_WAIT:  if (rsp_tready) state_in = (k_ff == (IdxBits+1)'(ord_ff)) ? ST_IDLE : ST_EMIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ord_cfg_ff <= 4'd4;
         cnt_cfg_ff <= 6'd4;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en && csr_index == CSR_ORDER) ord_cfg_ff <= csr_wdata[3:0];
         if (csr_wr_en && csr_index == CSR_COUNT) cnt_cfg_ff <= csr_wdata;
         if (state_ff == ST_EMIT) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            ord_ff <= OrdBits'(ord_c);
            n_ff <= n_c;
            u_ff <= req_tdata[39:23];
            k_ff <= (IdxBits+1)'(ord_c - 4'd1);
            span_ff <= IdxBits'(ord_c - 4'd1);
            j_ff <= OrdBits'(1);
            for (int i = 0; i < MaxOrder; i++) basis_ff[i] <= '0;
            basis_ff[0] <= OneVal;
            for (int i = 0; i <= MaxOrder; i++) begin
               left_ff[i] <= '0;
               right_ff[i] <= '0;
            end
         end
         ST_SCMP: begin
            if (rd_data <= u_ff) span_ff <= k_ff[IdxBits-1:0];
            k_ff <= k_ff + 1'b1;
         end
         ST_KRDR: begin
            left_ff[j_ff] <= (u_ff > rd_data) ? u_ff - rd_data : '0;
            r_ff <= '0;
            saved_ff <= '0;
         end
         ST_KSTR: right_ff[j_ff] <= (rd_data > u_ff) ? rd_data - u_ff : '0;
         ST_DIVST: begin
            den_ff <= DenBits'(rt_w) + DenBits'(lt_w);
            quo_ff <= QuoBits'(basis_ff[r_ff[BasIdxBits-1:0]]) << FracBits;
            rem_ff <= '0;
            dcnt_ff <= DivCntBits'(QuoBits - 1);
         end
         ST_DIV: begin
            // one restoring step per cycle; zero divisor leaves all ones, masked later
            if (!rem_sub[DenBits]) begin
               rem_ff <= rem_sub;
               quo_ff <= {quo_ff[QuoBits-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[QuoBits-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 1'b1;
            if (dcnt_ff == '0 && den_ff == '0) quo_ff <= '0;
         end
         ST_MULR: prod_ff <= ProdBits'(rt_w) * ProdBits'(quo_ff);
         ST_MULL: begin
            basis_ff[r_ff[BasIdxBits-1:0]] <= sum_w;
            saved_ff <= sat_one((ProdBits'(lt_w) * ProdBits'(quo_ff)) >> FracBits);
            if (r_ff + 1'b1 < j_ff) r_ff <= r_ff + 1'b1;
            else begin
               basis_ff[j_ff[BasIdxBits-1:0]] <=
                  sat_one((ProdBits'(lt_w) * ProdBits'(quo_ff)) >> FracBits);
               j_ff <= j_ff + 1'b1;
               k_ff <= '0;
            end
         end
         ST_EMIT: begin
            rsp_data_ff <= {3'b0, span_ff, basis_ff[k_ff[BasIdxBits-1:0]],
                            IdxBits'((IdxBits+1)'(span_ff) - (IdxBits+1)'(p_w) + k_ff)};
            rsp_last_ff <= (k_ff + 1'b1 == (IdxBits+1)'(ord_ff));
            k_ff <= k_ff + 1'b1;
         end
         default: ;
      endcase
      if (state_ff == ST_KRDR && j_ff == OrdBits'(1) && ord_ff == OrdBits'(1)) k_ff <= '0;
   end

   assign rsp_tvalid = rsp_valid_ff && (state_ff == ST_WAIT);
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_IMPLIES(a_busy_no_ready, clock, reset, state_ff != ST_IDLE, !req_tready, "ready while busy")
   `ASSERT_IMPLIES(a_out_in_wait, clock, reset, rsp_tvalid, state_ff == ST_WAIT, "output outside wait")
   `ASSERT_NEXT(a_eval_starts, clock, reset, acc_req && req_tuser == REQ_EVAL, state_ff == ST_SRD, "eval not started")
endmodule

// ----- design/bsbe_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bsbe_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
